// ===== rtl/core/jvm_type_descriptor_parser_defines.svh =====
// ----------------------------------------------------------------------------
// JVM type descriptor parser assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef JVM_TYPE_DESCRIPTOR_PARSER_DEFINES_SVH
`define JVM_TYPE_DESCRIPTOR_PARSER_DEFINES_SVH

// same-cycle implication
`define JTDP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jtdp: same-cycle check failed");

// next-cycle implication
`define JTDP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jtdp: next-cycle check failed");

`endif

// ===== rtl/core/jtdp_pkg.sv =====
// ----------------------------------------------------------------------------
// jtdp_pkg
// Types, codes and helpers shared by the descriptor parser modules.
// ----------------------------------------------------------------------------
package jtdp_pkg;

  localparam int NAME_COUNT_WIDTH = 16;
  localparam int DEPTH_WIDTH      = 8;
  localparam int ARG_WIDTH        = 8;

  localparam int CHAR_WIDTH  = 8;
  localparam int TDATA_WIDTH = 40;
  localparam int TUSER_WIDTH = 3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_J      = 8'h4A;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_V      = 8'h56;

  localparam logic [1:0] EV_TYPE   = 2'd0;
  localparam logic [1:0] EV_ACCEPT = 2'd1;
  localparam logic [1:0] EV_REJECT = 2'd2;

  localparam logic [1:0] KIND_PRIM  = 2'd0;
  localparam logic [1:0] KIND_CLASS = 2'd1;
  localparam logic [1:0] KIND_ARRAY = 2'd2;

  localparam logic [3:0] BASE_Z     = 4'd0;
  localparam logic [3:0] BASE_B     = 4'd1;
  localparam logic [3:0] BASE_C     = 4'd2;
  localparam logic [3:0] BASE_D     = 4'd3;
  localparam logic [3:0] BASE_F     = 4'd4;
  localparam logic [3:0] BASE_I     = 4'd5;
  localparam logic [3:0] BASE_J     = 4'd6;
  localparam logic [3:0] BASE_S     = 4'd7;
  localparam logic [3:0] BASE_V     = 4'd8;
  localparam logic [3:0] BASE_CLASS = 4'd9;

  typedef struct packed {
    logic [1:0]  event_res;
    logic        is_return;
    logic [7:0]  arg_index;
    logic [1:0]  type_kind;
    logic [3:0]  base_type;
    logic [7:0]  array_depth;
    logic [15:0] name_length;
  } res_t;

  typedef struct packed {
    logic emit;
    res_t res;
  } parse_out_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] code;
  } prim_t;

  function automatic prim_t prim_lookup(logic [7:0] c);
    prim_t p;
    p.valid = 1'b1;
    case (c)
      CH_Z:    p.code = BASE_Z;
      CH_B:    p.code = BASE_B;
      CH_C:    p.code = BASE_C;
      CH_D:    p.code = BASE_D;
      CH_F:    p.code = BASE_F;
      CH_I:    p.code = BASE_I;
      CH_J:    p.code = BASE_J;
      CH_S:    p.code = BASE_S;
      CH_V:    p.code = BASE_V;
      default: begin
        p.valid = 1'b0;
        p.code  = BASE_Z;
      end
    endcase
    return p;
  endfunction

  function automatic logic [7:0] clamp8(logic [31:0] v);
    return (v > 32'd255) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [15:0] clamp16(logic [31:0] v);
    return (v > 32'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// ===== rtl/core/jvm_type_descriptor_parser.sv =====
// ----------------------------------------------------------------------------
// jvm_type_descriptor_parser
// Streaming JVM method / field type descriptor parser, one byte per beat.
// ----------------------------------------------------------------------------
//  channel   | dir | beat contents
//  ----------+-----+--------------------------------------------------------
//  s_axis    | in  | tdata[7:0] char_code
//  m_axis    | out | tuser: event_res, is_return; tdata: per-type fields
//  cfg       | in  | cfg_wen / cfg_wdata = parse_mode
//
//  One byte per cycle unless the sink stalls; a byte's result is loaded into
//  the result register after the input register and parse state machine.
//  Bytes that make no result never wait on the sink.
//  Reset clears the parse state, parse_mode and both valid flags; no clear pass.
//  A stalled sink holds the result; one more byte waits in the input register.
// ----------------------------------------------------------------------------
`include "jvm_type_descriptor_parser_defines.svh"

module jvm_type_descriptor_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [jtdp_pkg::CHAR_WIDTH-1:0]    s_tdata,  // [7:0] char_code
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] arg_index, [9:8] type_kind, [13:10] base_type, [21:14] array_depth,
  // [37:22] name_length, [39:38] zero
  output logic [jtdp_pkg::TDATA_WIDTH-1:0]   m_tdata,
  output logic [jtdp_pkg::TUSER_WIDTH-1:0]   m_tuser,  // [1:0] event_res, [2] is_return
  input  logic                               cfg_wen,
  input  logic                               cfg_wdata
);

  logic                                  parse_mode;
  logic                                  in_valid;
  logic [jtdp_pkg::CHAR_WIDTH-1:0]       in_char;
  logic                                  step;
  logic                                  out_free;
  jtdp_pkg::parse_out_t                  pout;
  jtdp_pkg::res_t                        res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode <= 1'b0;
    end else if (cfg_wen) begin
      parse_mode <= cfg_wdata;
    end
  end

  assign step = in_valid && (!pout.emit || out_free);

  jtdp_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (step),
    .in_valid (in_valid),
    .in_char  (in_char)
  );

  jtdp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .char_code  (in_char),
    .parse_mode (parse_mode),
    .pout       (pout)
  );

  jtdp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step && pout.emit),
    .res_in   (pout.res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res_out  (res_q)
  );

  assign m_tuser = {res_q.is_return, res_q.event_res};
  assign m_tdata = {2'b00, res_q.name_length, res_q.array_depth, res_q.base_type,
                    res_q.type_kind, res_q.arg_index};

  `JTDP_ASSERT_IMP(a_drain_when_free, in_valid && !m_tvalid, step)
  `JTDP_ASSERT_IMP(a_event_fields_zero,
    m_tvalid && (res_q.event_res != jtdp_pkg::EV_TYPE), m_tdata == '0 && !res_q.is_return)
  `JTDP_ASSERT_IMP(a_return_index_zero,
    m_tvalid && res_q.is_return, res_q.arg_index == 8'd0)
  `JTDP_ASSERT_NXT(a_load_shows, step && pout.emit, m_tvalid)

endmodule

// ===== rtl/core/jtdp_in_reg.sv =====
// ----------------------------------------------------------------------------
// jtdp_in_reg
// Input register: holds one descriptor byte until the parser takes it.
// ----------------------------------------------------------------------------
module jtdp_in_reg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [jtdp_pkg::CHAR_WIDTH-1:0]  s_tdata,
  input  logic                             take,
  output logic                             in_valid,
  output logic [jtdp_pkg::CHAR_WIDTH-1:0]  in_char
);

  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
    end
  end

endmodule

// ===== rtl/core/jtdp_parse.sv =====
// ----------------------------------------------------------------------------
// jtdp_parse
// Descriptor grammar state machine with its counters; one byte per step.
// ----------------------------------------------------------------------------
module jtdp_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           char_code,
  input  logic                 parse_mode,
  output jtdp_pkg::parse_out_t pout
);

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_ARGS  = 3'd1,
    PH_RET   = 3'd2,
    PH_DONE  = 3'd3,
    PH_ARRAY = 3'd4,
    PH_NAME  = 3'd5,
    PH_SKIP  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    CTX_ARG   = 2'd0,
    CTX_RET   = 2'd1,
    CTX_FIELD = 2'd2
  } ctx_t;

  phase_t                              phase, phase_next;
  ctx_t                                ctx, ctx_next;
  logic [jtdp_pkg::DEPTH_WIDTH-1:0]      depth_count, depth_count_next;
  logic [jtdp_pkg::NAME_COUNT_WIDTH-1:0] name_count, name_count_next;
  logic [jtdp_pkg::ARG_WIDTH-1:0]        arg_count, arg_count_next;

  always_comb begin
    logic                                   do_type;
    logic                                   do_complete;
    logic                                   do_fail;
    ctx_t                                   tctx;
    logic [jtdp_pkg::DEPTH_WIDTH-1:0]      tdepth;
    logic [1:0]                             ckind;
    logic [3:0]                             cbase;
    jtdp_pkg::prim_t                        prim;

    do_type          = 1'b0;
    do_complete      = 1'b0;
    do_fail          = 1'b0;
    tctx             = ctx;
    tdepth           = depth_count;
    ckind            = jtdp_pkg::KIND_PRIM;
    cbase            = jtdp_pkg::BASE_Z;
    prim             = jtdp_pkg::prim_lookup(char_code);
    phase_next       = phase;
    ctx_next         = ctx;
    depth_count_next = depth_count;
    name_count_next  = name_count;
    arg_count_next   = arg_count;
    pout             = '0;

    unique case (phase)
      PH_START: begin
        if (parse_mode) begin
          tctx    = CTX_FIELD;
          tdepth  = '0;
          do_type = 1'b1;
        end else if (char_code == jtdp_pkg::CH_LPAREN) begin
          ctx_next       = CTX_ARG;
          arg_count_next = '0;
          phase_next     = PH_ARGS;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_ARGS: begin
        if (char_code == jtdp_pkg::CH_RPAREN) begin
          ctx_next   = CTX_RET;
          phase_next = PH_RET;
        end else begin
          tdepth  = '0;
          do_type = 1'b1;
        end
      end
      PH_RET: begin
        tdepth  = '0;
        do_type = 1'b1;
      end
      PH_ARRAY: begin
        do_type = 1'b1;
      end
      PH_NAME: begin
        if (char_code == jtdp_pkg::CH_SEMI) begin
          do_complete = 1'b1;
          ckind       = (depth_count != '0) ? jtdp_pkg::KIND_ARRAY : jtdp_pkg::KIND_CLASS;
          cbase       = jtdp_pkg::BASE_CLASS;
        end else if (char_code == jtdp_pkg::CH_NUL) begin
          do_fail = 1'b1;
        end else if (name_count != '1) begin
          name_count_next = name_count + jtdp_pkg::NAME_COUNT_WIDTH'(1);
        end
      end
      PH_DONE: begin
        if (char_code == jtdp_pkg::CH_NUL) begin
          phase_next           = PH_START;
          ctx_next             = CTX_ARG;
          depth_count_next     = '0;
          name_count_next      = '0;
          arg_count_next       = '0;
          pout.emit            = 1'b1;
          pout.res.event_res   = jtdp_pkg::EV_ACCEPT;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_SKIP: begin
        if (char_code == jtdp_pkg::CH_NUL) begin
          phase_next       = PH_START;
          ctx_next         = CTX_ARG;
          depth_count_next = '0;
          name_count_next  = '0;
          arg_count_next   = '0;
        end
      end
      default: begin
        phase_next       = PH_START;
        ctx_next         = CTX_ARG;
        depth_count_next = '0;
        name_count_next  = '0;
        arg_count_next   = '0;
      end
    endcase

    // first byte of a type, or a byte after brackets
    if (do_type) begin
      ctx_next         = tctx;
      depth_count_next = tdepth;
      if (prim.valid) begin
        do_complete = 1'b1;
        ckind       = (tdepth != '0) ? jtdp_pkg::KIND_ARRAY : jtdp_pkg::KIND_PRIM;
        cbase       = prim.code;
      end else if (char_code == jtdp_pkg::CH_L) begin
        name_count_next = '0;
        phase_next      = PH_NAME;
      end else if (char_code == jtdp_pkg::CH_LBRACK) begin
        depth_count_next = (tdepth != '1) ? tdepth + jtdp_pkg::DEPTH_WIDTH'(1) : tdepth;
        phase_next       = PH_ARRAY;
      end else begin
        do_fail = 1'b1;
      end
    end

    if (do_complete) begin
      pout.emit             = 1'b1;
      pout.res.event_res    = jtdp_pkg::EV_TYPE;
      pout.res.is_return    = (tctx == CTX_RET);
      pout.res.arg_index    = (tctx == CTX_ARG) ? jtdp_pkg::clamp8(32'(arg_count)) : 8'd0;
      pout.res.type_kind    = ckind;
      pout.res.base_type    = cbase;
      pout.res.array_depth  = jtdp_pkg::clamp8(32'(tdepth));
      pout.res.name_length  = (cbase == jtdp_pkg::BASE_CLASS)
                              ? jtdp_pkg::clamp16(32'(name_count)) : 16'd0;
      ctx_next         = tctx;
      depth_count_next = '0;
      name_count_next  = '0;
      if (tctx == CTX_ARG) begin
        arg_count_next = (arg_count != '1) ? arg_count + jtdp_pkg::ARG_WIDTH'(1) : arg_count;
        phase_next     = PH_ARGS;
      end else begin
        phase_next = PH_DONE;
      end
    end

    if (do_fail) begin
      pout               = '0;
      pout.emit          = 1'b1;
      pout.res.event_res = jtdp_pkg::EV_REJECT;
      phase_next         = (char_code != jtdp_pkg::CH_NUL) ? PH_SKIP : PH_START;
      ctx_next           = CTX_ARG;
      depth_count_next   = '0;
      name_count_next    = '0;
      arg_count_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      ctx         <= CTX_ARG;
      depth_count <= '0;
      name_count  <= '0;
      arg_count   <= '0;
    end else if (step) begin
      phase       <= phase_next;
      ctx         <= ctx_next;
      depth_count <= depth_count_next;
      name_count  <= name_count_next;
      arg_count   <= arg_count_next;
    end
  end

endmodule

// ===== rtl/core/jtdp_out_reg.sv =====
// ----------------------------------------------------------------------------
// jtdp_out_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module jtdp_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  jtdp_pkg::res_t res_in,
  output logic           out_free,
  output logic           m_tvalid,
  input  logic           m_tready,
  output jtdp_pkg::res_t res_out
);

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== dv/jvm_type_descriptor_parser_checker.sv =====
// ----------------------------------------------------------------------------
// jvm_type_descriptor_parser_checker
// Watches the byte, result and config channels of the descriptor parser. It
// keeps its own copy of the parse state, predicts the result beats and
// compares each one field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jvm_type_descriptor_parser_checker
  import jtdp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [CHAR_WIDTH-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [TDATA_WIDTH-1:0] m_tdata,
  input  logic [TUSER_WIDTH-1:0] m_tuser,
  input  logic                   cfg_wen,
  input  logic                   cfg_wdata,
  output int                     open_results,
  output int                     fail_count
);

  typedef enum logic [2:0] {
    ST_START, ST_ARGS, ST_RET, ST_DONE, ST_ARRAY, ST_NAME, ST_SKIP
  } parse_phase_e;

  typedef enum logic [1:0] {CTX_ARG, CTX_RET, CTX_FIELD} type_ctx_e;

  localparam logic [3:0] NOT_PRIM = 4'hF;

  parse_phase_e             phase;
  type_ctx_e                tctx;
  logic                     mode;
  logic [DEPTH_WIDTH-1:0]   depth;
  logic [NAME_COUNT_WIDTH-1:0] name_len;
  logic [ARG_WIDTH-1:0]     arg_num;
  res_t                     expected_events[$];
  res_t                     got_r;
  res_t                     want_r;
  int                       err_cnt;

  initial begin
    err_cnt = 0;
  end

  function automatic logic [3:0] prim_base(input logic [7:0] c);
    case (c)
      CH_Z:    return BASE_Z;
      CH_B:    return BASE_B;
      CH_C:    return BASE_C;
      CH_D:    return BASE_D;
      CH_F:    return BASE_F;
      CH_I:    return BASE_I;
      CH_J:    return BASE_J;
      CH_S:    return BASE_S;
      CH_V:    return BASE_V;
      default: return NOT_PRIM;
    endcase
  endfunction

  task automatic clear_parse();
    phase    = ST_START;
    depth    = '0;
    name_len = '0;
    arg_num  = '0;
    tctx     = CTX_ARG;
  endtask

  task automatic push_event(input logic [1:0] ev);
    res_t r;
    r = '0;
    r.event_res = ev;
    expected_events.push_back(r);
  endtask

  task automatic reject(input logic [7:0] c);
    clear_parse();
    if (c != CH_NUL) phase = ST_SKIP;
    push_event(EV_REJECT);
  endtask

  task automatic finish_type(input logic [1:0] kind, input logic [3:0] base);
    res_t r;
    r = '0;
    r.event_res   = EV_TYPE;
    r.is_return   = (tctx == CTX_RET);
    r.arg_index   = (tctx == CTX_ARG) ? arg_num : '0;
    r.type_kind   = kind;
    r.base_type   = base;
    r.array_depth = depth;
    r.name_length = (base == BASE_CLASS) ? name_len : '0;
    expected_events.push_back(r);
    if (tctx == CTX_ARG) begin
      if (arg_num != '1) arg_num++;
      phase = ST_ARGS;
    end else begin
      phase = ST_DONE;
    end
    depth    = '0;
    name_len = '0;
  endtask

  task automatic type_start(input logic [7:0] c);
    logic [3:0] code;
    code = prim_base(c);
    if (code != NOT_PRIM) begin
      finish_type((depth != 0) ? KIND_ARRAY : KIND_PRIM, code);
    end else if (c == CH_L) begin
      name_len = '0;
      phase    = ST_NAME;
    end else if (c == CH_LBRACK) begin
      if (depth != '1) depth++;
      phase = ST_ARRAY;
    end else begin
      reject(c);
    end
  endtask

  task automatic parse_byte(input logic [7:0] c);
    case (phase)
      ST_START: begin
        if (mode) begin
          tctx  = CTX_FIELD;
          depth = '0;
          type_start(c);
        end else if (c == CH_LPAREN) begin
          tctx    = CTX_ARG;
          arg_num = '0;
          phase   = ST_ARGS;
        end else begin
          reject(c);
        end
      end
      ST_ARGS: begin
        if (c == CH_RPAREN) begin
          tctx  = CTX_RET;
          phase = ST_RET;
        end else begin
          depth = '0;
          type_start(c);
        end
      end
      ST_RET: begin
        depth = '0;
        type_start(c);
      end
      ST_ARRAY: type_start(c);
      ST_NAME: begin
        if (c == CH_SEMI) finish_type((depth != 0) ? KIND_ARRAY : KIND_CLASS, BASE_CLASS);
        else if (c == CH_NUL) reject(c);
        else if (name_len != '1) name_len++;
      end
      ST_DONE: begin
        if (c == CH_NUL) begin
          clear_parse();
          push_event(EV_ACCEPT);
        end else begin
          reject(c);
        end
      end
      ST_SKIP: begin
        if (c == CH_NUL) clear_parse();
      end
      default: clear_parse();
    endcase
  endtask

  task automatic check_field(input string fname, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", fname, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_beat();
    got_r.event_res   = m_tuser[1:0];
    got_r.is_return   = m_tuser[2];
    got_r.arg_index   = m_tdata[7:0];
    got_r.type_kind   = m_tdata[9:8];
    got_r.base_type   = m_tdata[13:10];
    got_r.array_depth = m_tdata[21:14];
    got_r.name_length = m_tdata[37:22];
    if (expected_events.size() == 0) begin
      $error("result beat with no pending prediction: event_res %0d", got_r.event_res);
      err_cnt++;
    end else begin
      want_r = expected_events.pop_front();
      check_field("event_res",   want_r.event_res,   got_r.event_res);
      check_field("is_return",   want_r.is_return,   got_r.is_return);
      check_field("arg_index",   want_r.arg_index,   got_r.arg_index);
      check_field("type_kind",   want_r.type_kind,   got_r.type_kind);
      check_field("base_type",   want_r.base_type,   got_r.base_type);
      check_field("array_depth", want_r.array_depth, got_r.array_depth);
      check_field("name_length", want_r.name_length, got_r.name_length);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode = 1'b0;
      clear_parse();
      expected_events.delete();
    end else begin
      if (m_tvalid && m_tready) check_beat();
      if (cfg_wen) mode = cfg_wdata;
      if (s_tvalid && s_tready) parse_byte(s_tdata);
    end
    open_results <= expected_events.size();
    fail_count   <= err_cnt;
  end

endmodule

// ===== dv/jvm_type_descriptor_parser_tb.sv =====
// ----------------------------------------------------------------------------
// jvm_type_descriptor_parser_tb
// Feeds method and field descriptors, well-formed and broken, one byte per
// beat with random source gaps and sink stalls, switches parse_mode between
// phases and reports the verdict from the checker's failure and open-result counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jvm_type_descriptor_parser_tb;
  import jtdp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RAND_BYTES  = 110;

  localparam logic [7:0] PRIM_CH [9] = '{CH_Z, CH_B, CH_C, CH_D, CH_F, CH_I, CH_J, CH_S, CH_V};

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [CHAR_WIDTH-1:0]  s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [TDATA_WIDTH-1:0] m_tdata;
  logic [TUSER_WIDTH-1:0] m_tuser;
  logic                   cfg_wen   = 1'b0;
  logic                   cfg_wdata = 1'b0;

  int         open_results;
  int         fail_count;
  int         stall_cycles = 0;
  int         bytes_sent   = 0;
  int         descs_sent   = 0;
  int         mode_writes  = 0;
  int         rand_start;
  logic       cur_mode     = 1'b0;
  bit         quiet        = 1'b0;
  logic [7:0] desc_q[$];

  jvm_type_descriptor_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  jvm_type_descriptor_parser_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .open_results (open_results),
    .fail_count   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // hold the byte until taken; a gap only lowers tvalid on an edge of its own
  task automatic send_byte(input logic [7:0] c);
    if (!quiet && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_desc();
    foreach (desc_q[i]) send_byte(desc_q[i]);
    desc_q.delete();
    descs_sent++;
  endtask

  // drain the parser before touching parse_mode
  task automatic set_mode(input logic v);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    cur_mode = v;
    mode_writes++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) desc_q.push_back(s[i]);
  endtask

  task automatic add_name(input int len);
    logic [7:0] c;
    repeat (len) begin
      do c = 8'($urandom_range(255, 1)); while (c == CH_SEMI);
      desc_q.push_back(c);
    end
  endtask

  task automatic add_type();
    int n;
    n = ($urandom_range(99) < 30) ? $urandom_range(3, 1) : 0;
    repeat (n) desc_q.push_back(CH_LBRACK);
    if ($urandom_range(99) < 25) begin
      desc_q.push_back(CH_L);
      add_name(($urandom_range(99) < 85) ? $urandom_range(6) : $urandom_range(40, 7));
      desc_q.push_back(CH_SEMI);
    end else begin
      desc_q.push_back(PRIM_CH[$urandom_range(8)]);
    end
  endtask

  task automatic build_desc(input logic field);
    if (field) begin
      add_type();
    end else begin
      desc_q.push_back(CH_LPAREN);
      repeat ($urandom_range(4)) add_type();
      desc_q.push_back(CH_RPAREN);
      add_type();
    end
    desc_q.push_back(CH_NUL);
  endtask

  task automatic add_noise();
    int k;
    case ($urandom_range(3))
      0: begin
        repeat ($urandom_range(6, 1)) desc_q.push_back(8'($urandom_range(255)));
        desc_q.push_back(CH_NUL);
      end
      1: begin
        // cut short: terminator inside the descriptor
        build_desc(1'($urandom_range(1)));
        k = $urandom_range(desc_q.size() - 2);
        while (desc_q.size() > k) void'(desc_q.pop_back());
        desc_q.push_back(CH_NUL);
      end
      2: begin
        // trailing bytes after a complete descriptor
        build_desc(1'($urandom_range(1)));
        void'(desc_q.pop_back());
        repeat ($urandom_range(3, 1)) desc_q.push_back(8'($urandom_range(255, 1)));
        desc_q.push_back(CH_NUL);
      end
      default: begin
        build_desc(1'($urandom_range(1)));
        k = $urandom_range(desc_q.size() - 2);
        desc_q[k] = 8'($urandom_range(255));
      end
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: method descriptors
    set_mode(1'b0);
    desc_q.push_back(CH_NUL);
    send_desc();
    push_str("(L;[[Z)[LAB;");
    desc_q.push_back(CH_NUL);
    send_desc();
    desc_q.push_back(CH_LPAREN);
    desc_q.push_back(8'hFF);
    desc_q.push_back(CH_NUL);
    send_desc();
    push_str("(I");
    desc_q.push_back(CH_NUL);
    send_desc();
    push_str("()VV");
    desc_q.push_back(CH_NUL);
    send_desc();

    // saturate argument index and array depth in one method descriptor
    desc_q.push_back(CH_LPAREN);
    repeat (257) desc_q.push_back(CH_I);
    repeat (257) desc_q.push_back(CH_LBRACK);
    push_str("LAB;");
    desc_q.push_back(CH_RPAREN);
    desc_q.push_back(CH_V);
    desc_q.push_back(CH_NUL);
    send_desc();

    // directed: field type
    set_mode(1'b1);
    push_str("S");
    desc_q.push_back(CH_NUL);
    send_desc();

    // random descriptors, mostly well-formed
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RAND_BYTES) begin
      if ($urandom_range(99) < 6) set_mode(1'($urandom_range(1)));
      quiet <= (bytes_sent - rand_start >= 30) && (bytes_sent - rand_start < 80);
      if ($urandom_range(99) < 20) add_noise();
      else build_desc(cur_mode);
      send_desc();
    end

    quiet    <= 1'b0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d bytes in %0d descriptors, %0d parse_mode writes", bytes_sent,
             descs_sent, mode_writes);
    $display("both modes, malformed input and saturated depth and argument counters");
    if (fail_count == 0 && open_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
